>>> hdl/pixel_width_word_wrap_core_defines.svh
// Assertion macros for the pixel width word wrap checker.
// No dependencies.
`ifndef PIXEL_WIDTH_WORD_WRAP_CORE_DEFINES_SVH
`define PIXEL_WIDTH_WORD_WRAP_CORE_DEFINES_SVH

// same-cycle implication
`define PWWW_ASSERT_NOW(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define PWWW_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> hdl/pwww_pkg.sv
// Shared types and constants for the pixel width word wrap block.
// No dependencies.
package pwww_pkg;

   localparam int MAX_CHARS = 40;
   localparam int FILL_W    = $clog2(MAX_CHARS + 1);
   localparam int IDX_W     = $clog2(MAX_CHARS);

   localparam logic [7:0]  CODE_NL        = 8'd10;
   localparam logic [7:0]  CODE_SP        = 8'd32;
   localparam logic [11:0] LINE_WIDTH_RST = 12'd240;
   localparam logic [5:0]  ROWS_RST       = 6'd5;

   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_ROWS       = 1'b1;

   typedef enum logic [2:0] {
      BRK_NEWLINE = 3'd0,
      BRK_CUT     = 3'd1,
      BRK_WIDTH   = 3'd2,
      BRK_CAP     = 3'd3,
      BRK_END     = 3'd4
   } brk_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_EOT,
      OP_APPEND,
      OP_NEWLINE,
      OP_CUT,
      OP_WBREAK,
      OP_RD,
      OP_WR,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic eot;
      logic fill_zero;
      logic is_nl;
      logic overflow;
      logic can_cut;
      logic cap_next;
      logic can_emit;
      logic out_free;
      logic pend_v;
      logic copy_done;
   } stat_type;

   typedef struct packed {
      logic [5:0]  row;
      logic [31:0] start;
      logic [5:0]  shown;
      brk_type     kind;
      logic        lop;
   } res_type;

endpackage

>>> hdl/pixel_width_word_wrap_core.sv
// Top level of the pixel width word wrap block.
// Depends on pwww_pkg, pwww_csr, pwww_ctrl and pwww_dpath.
//
// Input channel req_*: one beat is a character (code, pixel width, byte
// offset) or an end-of-text mark. Output channel rsp_*: one beat per
// finished display row; rsp_last_of_item marks the final row caused by an
// input beat. Both channels use valid/ready.
// Configuration: APB-style port, line width at address 0, rows per page at
// address 4; write only while the block is idle.
// Timing: req_ready drops after an accept and returns once the beat has
// passed the evaluate and finish states, so no new beat is taken before
// the last is through; a beat that finishes rows has its last row appear
// at rsp_* as req_ready returns. A cut at a space replays the characters
// after the space from the row memory, a read state then a write state
// per character, through the single read and write port.
// Rows are held in a pending slot and an output register; when the receiver
// stalls, the controller waits on those two before the next row or beat.
// Reset (synchronous, active high) empties the row, restarts the page at
// row 0 and loads the register defaults (240 pixels, 5 rows).
module pixel_width_word_wrap_core
   import pwww_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_char_width_px,
   input  logic [31:0] req_char_offset,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_row_in_page,
   output logic [31:0] rsp_line_start_offset,
   output logic [5:0]  rsp_shown_chars,
   output logic [2:0]  rsp_break_kind,
   output logic        rsp_last_of_page,
   output logic        rsp_last_of_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [11:0] line_width_px;
   logic [5:0]  rows_per_page;
   cmd_type     cmd;
   stat_type    stat;

   pwww_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .line_width_px (line_width_px),
      .rows_per_page (rows_per_page)
   );

   pwww_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwww_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .line_width_px         (line_width_px),
      .rows_per_page         (rows_per_page),
      .req_char_code         (req_char_code),
      .req_char_width_px     (req_char_width_px),
      .req_char_offset       (req_char_offset),
      .req_end_of_text       (req_end_of_text),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_row_in_page       (rsp_row_in_page),
      .rsp_line_start_offset (rsp_line_start_offset),
      .rsp_shown_chars       (rsp_shown_chars),
      .rsp_break_kind        (rsp_break_kind),
      .rsp_last_of_page      (rsp_last_of_page),
      .rsp_last_of_item      (rsp_last_of_item)
   );

endmodule

>>> hdl/pwww_csr.sv
// Configuration registers behind the APB-style port.
// Depends on pwww_pkg.
module pwww_csr
   import pwww_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [11:0] line_width_px,
   output logic [5:0]  rows_per_page
);

   logic [11:0] width_ff;
   logic [5:0]  rows_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= LINE_WIDTH_RST;
         rows_ff  <= ROWS_RST;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_LINE_WIDTH: width_ff <= pwdata[11:0];
            REG_ROWS:       rows_ff  <= pwdata[5:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LINE_WIDTH: prdata = {20'd0, width_ff};
         REG_ROWS:       prdata = {26'd0, rows_ff};
         default:        prdata = 32'd0;
      endcase
   end

   assign line_width_px = width_ff;
   assign rows_per_page = rows_ff;

endmodule

>>> hdl/pwww_dpath.sv
// Datapath: row buffer memory, row state, pending result and output register.
// Depends on pwww_pkg; driven by pwww_ctrl commands.
module pwww_dpath
   import pwww_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [11:0] line_width_px,
   input  logic [5:0]  rows_per_page,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_char_width_px,
   input  logic [31:0] req_char_offset,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_row_in_page,
   output logic [31:0] rsp_line_start_offset,
   output logic [5:0]  rsp_shown_chars,
   output logic [2:0]  rsp_break_kind,
   output logic        rsp_last_of_page,
   output logic        rsp_last_of_item
);

   logic [47:0] mem [MAX_CHARS];
   logic [47:0] rd_q_ff;

   logic [7:0]  cur_code_ff;
   logic [7:0]  cur_w_ff;
   logic [31:0] cur_off_ff;
   logic        cur_eot_ff;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [12:0]       sum_ff, sum_in;
   logic [5:0]        row_ff, row_in;
   logic [FILL_W-1:0] last_sp_ff, last_sp_in;
   logic [7:0]        last_code_ff, last_code_in;
   logic [31:0]       start_ff, start_in;
   logic [FILL_W-1:0] src_ff, src_in;
   logic [FILL_W-1:0] end_ff, end_in;

   res_type pend_ff, pend_in;
   logic    pend_v_ff, pend_v_in;
   res_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_v_ff, out_v_in;

   logic [7:0]  app_code, app_w;
   logic [31:0] app_off;
   logic        app_en;
   logic        em_v;
   brk_type     em_kind;
   logic [FILL_W-1:0] em_shown;
   logic [31:0] em_start;
   logic        lop;
   logic        out_free;
   logic        can_emit;

   assign out_free = !out_v_ff || rsp_ready;
   assign can_emit = !pend_v_ff || out_free;

   always_comb begin
      stat.eot       = cur_eot_ff;
      stat.fill_zero = (fill_ff == '0);
      stat.is_nl     = (cur_code_ff == CODE_NL);
      stat.overflow  = ({1'b0, sum_ff} + {6'd0, cur_w_ff}) > {2'b00, line_width_px};
      stat.can_cut   = (last_code_ff != CODE_SP) && (last_sp_ff != '0);
      stat.cap_next  = ({1'b0, fill_ff} + 1'b1) >= (FILL_W + 1)'(MAX_CHARS);
      stat.can_emit  = can_emit;
      stat.out_free  = out_free;
      stat.pend_v    = pend_v_ff;
      stat.copy_done = (src_ff == end_ff);
   end

   always_comb begin
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      row_in       = row_ff;
      last_sp_in   = last_sp_ff;
      last_code_in = last_code_ff;
      start_in     = start_ff;
      src_in       = src_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      app_en       = 1'b0;
      app_code     = cur_code_ff;
      app_w        = cur_w_ff;
      app_off      = cur_off_ff;
      em_v         = 1'b0;
      em_kind      = BRK_END;
      em_shown     = fill_ff;
      em_start     = start_ff;
      lop          = 1'b0;

      case (cmd.op)
         OP_APPEND: app_en = 1'b1;
         OP_WR: begin
            app_en   = 1'b1;
            app_code = rd_q_ff[47:40];
            app_w    = rd_q_ff[39:32];
            app_off  = rd_q_ff[31:0];
         end
         OP_RD:      src_in = src_ff + 1'b1;
         OP_EOT:     em_v = !stat.fill_zero;
         OP_NEWLINE: begin
            em_v    = 1'b1;
            em_kind = BRK_NEWLINE;
         end
         OP_WBREAK: begin
            em_v    = 1'b1;
            em_kind = BRK_WIDTH;
         end
         OP_CUT: begin
            em_v     = 1'b1;
            em_kind  = BRK_CUT;
            em_shown = last_sp_ff;
            src_in   = last_sp_ff + 1'b1;
            end_in   = fill_ff;
         end
         OP_FLUSH: begin
            out_in      = pend_ff;
            out_last_in = 1'b1;
            out_v_in    = 1'b1;
            pend_v_in   = 1'b0;
         end
         default: ;
      endcase

      if (app_en) begin
         fill_in      = fill_ff + 1'b1;
         sum_in       = sum_ff + {5'd0, app_w};
         last_code_in = app_code;
         if (stat.fill_zero) begin
            start_in = app_off;
         end
         if (app_code == CODE_SP && !stat.fill_zero) begin
            last_sp_in = fill_ff;
         end
         if (cmd.op == OP_APPEND && stat.cap_next) begin
            em_v     = 1'b1;
            em_kind  = BRK_CAP;
            em_shown = fill_in;
            em_start = start_in;
         end
      end

      if (em_v) begin
         lop = (em_kind == BRK_END) || (({1'b0, row_ff} + 1'b1) >= {1'b0, rows_per_page});
         if (pend_v_ff) begin
            out_in      = pend_ff;
            out_last_in = 1'b0;
            out_v_in    = 1'b1;
         end
         pend_in.row   = row_ff;
         pend_in.start = em_start;
         pend_in.shown = 6'(em_shown);
         pend_in.kind  = em_kind;
         pend_in.lop   = lop;
         pend_v_in     = 1'b1;
         row_in        = lop ? 6'd0 : row_ff + 1'b1;
         fill_in       = '0;
         sum_in        = '0;
         last_sp_in    = '0;
      end

      if (cmd.op == OP_EOT) begin
         row_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (app_en) begin
         mem[fill_ff[IDX_W-1:0]] <= {app_code, app_w, app_off};
      end
      if (cmd.op == OP_RD) begin
         rd_q_ff <= mem[src_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         sum_ff     <= '0;
         row_ff     <= '0;
         last_sp_ff <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         row_ff     <= row_in;
         last_sp_ff <= last_sp_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         cur_code_ff <= req_char_code;
         cur_w_ff    <= req_char_width_px;
         cur_off_ff  <= req_char_offset;
         cur_eot_ff  <= req_end_of_text;
      end
      last_code_ff <= last_code_in;
      start_ff     <= start_in;
      src_ff       <= src_in;
      end_ff       <= end_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_row_in_page       = out_ff.row;
   assign rsp_line_start_offset = out_ff.start;
   assign rsp_shown_chars       = out_ff.shown;
   assign rsp_break_kind        = out_ff.kind;
   assign rsp_last_of_page      = out_ff.lop;
   assign rsp_last_of_item      = out_last_ff;

endmodule

>>> hdl/pwww_ctrl.sv
// Controller state machine sequencing one input beat through the datapath.
// Depends on pwww_pkg.
module pwww_ctrl
   import pwww_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RD,
      ST_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      emits;

   always_comb begin
      if (stat.eot) begin
         emits = !stat.fill_zero;
      end else if (stat.fill_zero) begin
         emits = !stat.is_nl && stat.cap_next;
      end else begin
         emits = stat.is_nl || stat.overflow || stat.cap_next;
      end
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.op   = OP_LOAD;
               state_in = ST_EVAL;
               ready_in = 1'b0;
            end
         end
         ST_EVAL: begin
            if (!emits || stat.can_emit) begin
               if (stat.eot) begin
                  cmd.op   = OP_EOT;
                  state_in = ST_FINISH;
               end else if (stat.fill_zero && stat.is_nl) begin
                  state_in = ST_FINISH;
               end else if (stat.fill_zero) begin
                  cmd.op   = OP_APPEND;
                  state_in = ST_FINISH;
               end else if (stat.is_nl) begin
                  cmd.op   = OP_NEWLINE;
                  state_in = ST_FINISH;
               end else if (stat.overflow && stat.can_cut) begin
                  cmd.op   = OP_CUT;
                  state_in = ST_RD;
               end else if (stat.overflow) begin
                  cmd.op   = OP_WBREAK;
               end else begin
                  cmd.op   = OP_APPEND;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RD: begin
            cmd.op   = OP_RD;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.op   = OP_WR;
            state_in = stat.copy_done ? ST_EVAL : ST_RD;
         end
         ST_FINISH: begin
            if (!stat.pend_v) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end else if (stat.out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

>>> hdl/pwww_checker.sv
// Port-level checker for pixel_width_word_wrap_core, with its bind.
// Depends on pwww_pkg and pixel_width_word_wrap_core_defines.svh.
`include "pixel_width_word_wrap_core_defines.svh"
module pwww_checker
   import pwww_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_row_in_page,
   input logic [2:0] rsp_break_kind,
   input logic       rsp_last_of_page,
   input logic       rsp_last_of_item
);

   `PWWW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
   `PWWW_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "req_ready after accept")
   `PWWW_ASSERT_NOW(a_kind, clock, reset, rsp_valid, rsp_break_kind <= BRK_END, "bad break kind")
   `PWWW_ASSERT_NOW(a_end_row, clock, reset, rsp_valid && rsp_break_kind == BRK_END, rsp_last_of_page && rsp_last_of_item, "end row not last")
   `PWWW_ASSERT_NOW(a_row_range, clock, reset, rsp_valid, rsp_row_in_page != 6'd63, "row out of range")

endmodule

bind pixel_width_word_wrap_core pwww_checker u_pwww_checker (.*);
